// ===== rtl/u8n_pkg.sv =====
package u8n_pkg;

    localparam int unsigned MaxOut = 4;

    localparam logic [20:0] CodeLimit   = 21'h110000;
    localparam logic [20:0] CodeReplace = 21'h00FFFD;
    localparam logic [20:0] Lim2Byte    = 21'h000080;
    localparam logic [20:0] Lim3Byte    = 21'h000800;
    localparam logic [20:0] Lim4Byte    = 21'h010000;
    localparam logic [7:0]  LeadMax     = 8'hF4;

    typedef struct packed {
        logic [20:0] acc;
        logic [1:0]  pend;
    } t_seq_st;

    typedef struct packed {
        logic [MaxOut-1:0][7:0] bytes;
        logic [2:0]             num;
    } t_grp;

endpackage

// ===== rtl/u8n_dec.sv =====
module u8n_dec
    import u8n_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    input  t_seq_st    i_st,
    output t_seq_st    o_st,
    output t_grp       o_grp
);

    function automatic t_grp encode(input logic [20:0] code);
        logic [20:0] u;
        t_grp        g;
        u = (code >= CodeLimit) ? CodeReplace : code;
        g = '0;
        if (u < Lim2Byte) begin
            g.bytes[0] = u[7:0];
            g.num      = 3'd1;
        end else if (u < Lim3Byte) begin
            g.bytes[0] = {3'b110, u[10:6]};
            g.bytes[1] = {2'b10, u[5:0]};
            g.num      = 3'd2;
        end else if (u < Lim4Byte) begin
            g.bytes[0] = {4'b1110, u[15:12]};
            g.bytes[1] = {2'b10, u[11:6]};
            g.bytes[2] = {2'b10, u[5:0]};
            g.num      = 3'd3;
        end else begin
            g.bytes[0] = {5'b11110, u[20:18]};
            g.bytes[1] = {2'b10, u[17:12]};
            g.bytes[2] = {2'b10, u[11:6]};
            g.bytes[3] = {2'b10, u[5:0]};
            g.num      = 3'd4;
        end
        return g;
    endfunction

    logic        fresh;
    logic        is_cont;
    logic [20:0] shifted;

    assign is_cont = (i_byte[7:6] == 2'b10);
    assign shifted = {i_st.acc[14:0], i_byte[5:0]};

    always_comb begin
        fresh = 1'b1;
        o_st  = i_st;
        o_grp = '0;
        if (i_st.pend != 2'd0) begin
            if (is_cont) begin
                fresh     = 1'b0;
                o_st.acc  = shifted;
                o_st.pend = i_st.pend - 2'd1;
                if (i_st.pend == 2'd1) begin
                    o_grp    = encode(shifted);
                    o_st.acc = '0;
                end
            end else begin
                o_st = '0;
            end
        end
        if (fresh) begin
            if (i_byte[7] == 1'b0) begin
                o_grp.bytes[0] = i_byte;
                o_grp.num      = 3'd1;
            end else if (i_byte < 8'hC0 || i_byte > LeadMax) begin
                o_grp.num = 3'd0;
            end else if (i_byte < 8'hE0) begin
                o_st.acc  = {16'd0, i_byte[4:0]};
                o_st.pend = 2'd1;
            end else if (i_byte < 8'hF0) begin
                o_st.acc  = {17'd0, i_byte[3:0]};
                o_st.pend = 2'd2;
            end else begin
                o_st.acc  = {18'd0, i_byte[2:0]};
                o_st.pend = 2'd3;
            end
        end
        if (i_eos) begin
            o_st = '0;
        end
    end

endmodule

// ===== rtl/utf8_shortest_form_normalizer.sv =====
// utf8_shortest_form_normalizer
// input channel: one raw byte per beat (i_in_byte, i_end_of_stream) under
// i_in_valid / o_in_ready. output channel: one cleaned byte per beat
// (o_out_byte, o_run_last) under o_out_valid / i_out_ready; o_run_last marks
// the final byte produced by one input beat.
// an input beat lands in an input register; the decoder and shortest-form
// encoder turn it into a group of 0 to 4 bytes, and a group of 1 to 4 bytes
// is loaded into the result register once that register is free, where its
// first byte is shown. one input beat per cycle is taken while output groups
// hold one byte each and the receiver does not stall; a group of n bytes is
// shown one byte at a time, and a beat that produces bytes waits in the input
// register until the last byte of the current group is taken. beats that
// produce nothing pass the input register even while a group drains. reset
// clears the open sequence, the input valid flag, the result valid flag and
// the byte position. when the receiver stalls, the shown byte holds; once the
// input register holds a beat that produces bytes, o_in_ready drops.
module utf8_shortest_form_normalizer
    import u8n_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_eos;
    t_seq_st    r_st;
    t_seq_st    n_st;
    t_grp       r_grp;
    t_grp       n_grp;
    logic       r_grp_vld;
    logic [1:0] r_pos;

    logic grp_last;
    logic grp_free;
    logic s1_move;

    u8n_dec u_dec (
        .i_byte (r_in_byte),
        .i_eos  (r_in_eos),
        .i_st   (r_st),
        .o_st   (n_st),
        .o_grp  (n_grp)
    );

    assign grp_last    = ({1'b0, r_pos} + 3'd1) == r_grp.num;
    assign grp_free    = !r_grp_vld || (i_out_ready && grp_last);
    assign s1_move     = r_in_vld && (grp_free || n_grp.num == 3'd0);
    assign o_in_ready  = !r_in_vld || s1_move;

    assign o_out_valid = r_grp_vld;
    assign o_out_byte  = r_grp.bytes[r_pos];
    assign o_run_last  = grp_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (s1_move) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_vld <= 1'b0;
            r_pos     <= 2'd0;
        end else if (s1_move && n_grp.num != 3'd0 && grp_free) begin
            r_grp_vld <= 1'b1;
            r_pos     <= 2'd0;
        end else if (r_grp_vld && i_out_ready) begin
            if (grp_last) begin
                r_grp_vld <= 1'b0;
                r_pos     <= 2'd0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && n_grp.num != 3'd0 && grp_free) begin
            r_grp <= n_grp;
        end
    end

    a_grp_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp_vld |-> (r_grp.num != 3'd0 && {1'b0, r_pos} < r_grp.num))
        else $error("result group empty or position past its end");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_in_eos) |=> (r_st.pend == 2'd0 && r_st.acc == '0))
        else $error("open sequence survived end of stream");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grp_vld && !i_out_ready) |=> (r_grp_vld && $stable(r_pos)))
        else $error("stalled result group changed");

    a_producing_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && n_grp.num != 3'd0) |-> grp_free)
        else $error("producing beat moved while result group busy");

endmodule
